// ===== design/ers_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_pkg
// Types, codes and helpers shared by the event record summarizer files.
// ----------------------------------------------------------------------------
package ers_pkg;

  localparam int CH_NUM = 4;
  localparam int CH_W   = $clog2(CH_NUM);

  localparam logic [20:0] MAX_RECORD_WORDS = 21'd1048576;

  localparam logic [7:0] TYPE_PEAK  = 8'd0;
  localparam logic [7:0] TYPE_CYCLE = 8'd1;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_BAD_TYPE       = 2'd1,
    ST_LAST_NOT_CYCLE = 2'd2,
    ST_COUNT_MISMATCH = 2'd3
  } status_t;

  // per-channel accumulator entry, one RAM word
  typedef struct packed {
    logic [20:0] peak_words;
    logic [15:0] peak_max;
    logic [20:0] cycle_words;
    logic [31:0] event_sum;
    logic [15:0] latest_qmax;
    logic [23:0] latest_index;
  } chan_acc_t;

  localparam int ACC_W = $bits(chan_acc_t);

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [20:0]     chan_peak_words;
    logic [15:0]     peak_magnitude_max;
    logic [20:0]     chan_cycle_words;
    logic [31:0]     cycle_event_sum;
    logic [15:0]     cycle_latest_qmax;
    logic [23:0]     cycle_latest_index;
    logic [20:0]     total_peak_words;
    logic [20:0]     total_cycle_words;
    status_t         status;
    logic            last_row;
  } summary_row_t;

  function automatic logic [20:0] sat_inc(logic [20:0] v);
    return (v < MAX_RECORD_WORDS) ? v + 21'd1 : MAX_RECORD_WORDS;
  endfunction

endpackage

// ===== design/ers_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_in_if / ers_out_if
// Valid/ready channels for event words and summary rows.
// ----------------------------------------------------------------------------
interface ers_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] event_word;
  logic        record_end;
  logic [20:0] expected_peak_words;
  logic [20:0] expected_cycle_words;

  modport source (output valid, event_word, record_end, expected_peak_words,
                  expected_cycle_words, input ready);
  modport sink   (input valid, event_word, record_end, expected_peak_words,
                  expected_cycle_words, output ready);
endinterface

interface ers_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic [20:0] chan_peak_words;
  logic [15:0] peak_magnitude_max;
  logic [20:0] chan_cycle_words;
  logic [31:0] cycle_event_sum;
  logic [15:0] cycle_latest_qmax;
  logic [23:0] cycle_latest_index;
  logic [20:0] total_peak_words;
  logic [20:0] total_cycle_words;
  logic [1:0]  status;
  logic        last_row;

  modport source (output valid, channel, chan_peak_words, peak_magnitude_max,
                  chan_cycle_words, cycle_event_sum, cycle_latest_qmax,
                  cycle_latest_index, total_peak_words, total_cycle_words, status,
                  last_row, input ready);
  modport sink   (input valid, channel, chan_peak_words, peak_magnitude_max,
                  chan_cycle_words, cycle_event_sum, cycle_latest_qmax,
                  cycle_latest_index, total_peak_words, total_cycle_words, status,
                  last_row, output ready);
endinterface

// ===== design/event_record_summarizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_record_summarizer_unit
// Decodes peak and cycle event words, accumulates per-channel statistics in
// a small RAM and emits four summary rows at the end of each record.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  in_ch     in         valid/ready   event_word, record_end, expected counts
//  out_ch    out        valid/ready   one summary row per channel, 0 to 3
//
//  One event word per ready cycle; each word reads its channel entry, then
//  updates and writes it back in the next cycle, with write forwarding.
//  A record-end word holds in_ch off through its own update, then four row
//  reads through the RAM read port; in_ch reopens the cycle after the last.
//  Reset is synchronous; per-entry valid bits make every entry read zero.
//  Result stalls back up through a two-entry row queue into the readout.
// ----------------------------------------------------------------------------
module event_record_summarizer_unit
  import ers_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  ers_in_if.sink    in_ch,
  ers_out_if.source out_ch
);

  // stage 0: accept and read issue
  logic            in_fire;
  logic [7:0]      in_type;
  logic [CH_W-1:0] in_ch_sel;
  logic            sweep_issue;
  logic            rd_en;
  logic [CH_W-1:0] rd_addr;
  logic [2:0]      q_room;
  logic            q_pop;
  logic [1:0]      q_count;

  logic [CH_NUM-1:0] valid_r;
  logic [2:0]        sweep_left_r;
  logic [CH_W-1:0]   sweep_idx_r;

  // stage 1
  logic            s1_item_r;
  logic            s1_sweep_r;
  logic [63:0]     s1_word_r;
  logic            s1_end_r;
  logic [20:0]     s1_exp_peak_r;
  logic [20:0]     s1_exp_cycle_r;
  logic [CH_W-1:0] rd_addr_r;
  logic            rd_valid_r;
  logic [ACC_W-1:0] ram_q;

  logic            wr_q_en_r;
  logic [CH_W-1:0] wr_q_addr_r;
  chan_acc_t       wr_q_data_r;

  chan_acc_t cur;
  chan_acc_t upd;
  logic      take;
  logic      is_peak;
  logic      is_cycle;
  logic      wr_en;
  logic [15:0] raw_q;
  logic [15:0] mag;

  logic [20:0] total_peak_r, total_peak_nxt;
  logic [20:0] total_cycle_r, total_cycle_nxt;
  logic        latest_cycle_r, latest_cycle_nxt;
  logic        bad_r, bad_nxt;
  status_t     status_nxt;
  logic        rec_done;

  logic [20:0] snap_peak_r;
  logic [20:0] snap_cycle_r;
  status_t     snap_status_r;

  summary_row_t row;
  summary_row_t q_row;
  logic         row_push;

  // ---------------- stage 0 ----------------
  assign in_ch.ready = (sweep_left_r == 3'd0) && !(s1_item_r && s1_end_r);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_type     = in_ch.event_word[63:56];
  assign in_ch_sel   = (in_type == TYPE_CYCLE) ? in_ch.event_word[31:30]
                                               : in_ch.event_word[26:25];

  // keep queue fill plus row read in flight within two slots
  assign q_pop       = out_ch.valid && out_ch.ready;
  assign q_room      = {1'b0, q_count} + {2'b00, s1_sweep_r} - {2'b00, q_pop};
  assign sweep_issue = (sweep_left_r != 3'd0) && (q_room < 3'd2);

  assign rd_en   = in_fire || sweep_issue;
  assign rd_addr = sweep_issue ? sweep_idx_r : in_ch_sel;

  ers_ram #(
    .WIDTH (ACC_W),
    .DEPTH (CH_NUM)
  ) u_acc_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd_addr_r),
    .wdata (upd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r  <= rd_addr;
      rd_valid_r <= valid_r[rd_addr];
    end
    if (in_fire) begin
      s1_word_r      <= in_ch.event_word;
      s1_end_r       <= in_ch.record_end;
      s1_exp_peak_r  <= in_ch.expected_peak_words;
      s1_exp_cycle_r <= in_ch.expected_cycle_words;
    end
    wr_q_addr_r <= rd_addr_r;
    wr_q_data_r <= upd;
  end

  // ---------------- stage 1 ----------------
  // previous write lands in the RAM after this read was taken
  always_comb begin
    if (wr_q_en_r && (wr_q_addr_r == rd_addr_r)) begin
      cur = wr_q_data_r;
    end else if (rd_valid_r) begin
      cur = chan_acc_t'(ram_q);
    end else begin
      cur = '0;
    end
  end

  assign take     = s1_item_r && !bad_r;
  assign is_peak  = (s1_word_r[63:56] == TYPE_PEAK);
  assign is_cycle = (s1_word_r[63:56] == TYPE_CYCLE);
  assign raw_q    = s1_word_r[55:40];
  assign mag      = raw_q[15] ? (~raw_q + 16'd1) : raw_q;
  assign wr_en    = take && (is_peak || is_cycle);
  assign rec_done = s1_item_r && s1_end_r;

  always_comb begin
    upd = cur;
    if (is_peak) begin
      upd.peak_words = sat_inc(cur.peak_words);
      if (mag > cur.peak_max) begin
        upd.peak_max = mag;
      end
    end else begin
      upd.cycle_words  = sat_inc(cur.cycle_words);
      upd.event_sum    = cur.event_sum + {18'd0, s1_word_r[29:16]};
      upd.latest_qmax  = s1_word_r[15:0];
      upd.latest_index = s1_word_r[55:32];
    end
  end

  always_comb begin
    total_peak_nxt   = total_peak_r;
    total_cycle_nxt  = total_cycle_r;
    latest_cycle_nxt = latest_cycle_r;
    bad_nxt          = bad_r;
    if (take) begin
      if (is_peak) begin
        total_peak_nxt   = sat_inc(total_peak_r);
        latest_cycle_nxt = 1'b0;
      end else if (is_cycle) begin
        total_cycle_nxt  = sat_inc(total_cycle_r);
        latest_cycle_nxt = 1'b1;
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (bad_nxt) begin
      status_nxt = ST_BAD_TYPE;
    end else if (!latest_cycle_nxt) begin
      status_nxt = ST_LAST_NOT_CYCLE;
    end else if ((total_peak_nxt != s1_exp_peak_r) ||
                 (total_cycle_nxt != s1_exp_cycle_r)) begin
      status_nxt = ST_COUNT_MISMATCH;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_done) begin
      snap_peak_r   <= total_peak_nxt;
      snap_cycle_r  <= total_cycle_nxt;
      snap_status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r      <= 1'b0;
      s1_sweep_r     <= 1'b0;
      wr_q_en_r      <= 1'b0;
      valid_r        <= '0;
      sweep_left_r   <= 3'd0;
      sweep_idx_r    <= '0;
      total_peak_r   <= '0;
      total_cycle_r  <= '0;
      latest_cycle_r <= 1'b0;
      bad_r          <= 1'b0;
    end else begin
      s1_item_r  <= in_fire;
      s1_sweep_r <= sweep_issue;
      wr_q_en_r  <= wr_en;
      if (wr_en) begin
        valid_r[rd_addr_r] <= 1'b1;
      end
      // readout clears each entry as its row is read
      if (sweep_issue) begin
        valid_r[sweep_idx_r] <= 1'b0;
        sweep_idx_r          <= sweep_idx_r + 1'b1;
        sweep_left_r         <= sweep_left_r - 3'd1;
      end
      if (rec_done) begin
        sweep_left_r   <= 3'(CH_NUM);
        sweep_idx_r    <= '0;
        total_peak_r   <= '0;
        total_cycle_r  <= '0;
        latest_cycle_r <= 1'b0;
        bad_r          <= 1'b0;
      end else begin
        total_peak_r   <= total_peak_nxt;
        total_cycle_r  <= total_cycle_nxt;
        latest_cycle_r <= latest_cycle_nxt;
        bad_r          <= bad_nxt;
      end
    end
  end

  // ---------------- summary rows ----------------
  always_comb begin
    row.channel            = rd_addr_r;
    row.chan_peak_words    = cur.peak_words;
    row.peak_magnitude_max = cur.peak_max;
    row.chan_cycle_words   = cur.cycle_words;
    row.cycle_event_sum    = cur.event_sum;
    row.cycle_latest_qmax  = cur.latest_qmax;
    row.cycle_latest_index = cur.latest_index;
    row.total_peak_words   = snap_peak_r;
    row.total_cycle_words  = snap_cycle_r;
    row.status             = snap_status_r;
    row.last_row           = (rd_addr_r == CH_W'(CH_NUM - 1));
  end

  assign row_push = s1_sweep_r;

  ers_row_queue u_row_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (row_push),
    .push_row  (row),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .pop_row   (q_row),
    .count     (q_count)
  );

  assign out_ch.channel            = q_row.channel;
  assign out_ch.chan_peak_words    = q_row.chan_peak_words;
  assign out_ch.peak_magnitude_max = q_row.peak_magnitude_max;
  assign out_ch.chan_cycle_words   = q_row.chan_cycle_words;
  assign out_ch.cycle_event_sum    = q_row.cycle_event_sum;
  assign out_ch.cycle_latest_qmax  = q_row.cycle_latest_qmax;
  assign out_ch.cycle_latest_index = q_row.cycle_latest_index;
  assign out_ch.total_peak_words   = q_row.total_peak_words;
  assign out_ch.total_cycle_words  = q_row.total_cycle_words;
  assign out_ch.status             = q_row.status;
  assign out_ch.last_row           = q_row.last_row;

  // ---------------- assertions ----------------
  a_end_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.record_end |=> !in_ch.ready)
    else $error("input taken right after a record-end transfer");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    row_push |-> (q_count < 2'd2) || out_ch.ready)
    else $error("summary row pushed into a full queue");

  a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_item_r && s1_sweep_r))
    else $error("event update and row readout share a cycle");

  a_last_row_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_row == (out_ch.channel == 2'd3)))
    else $error("last row flag does not match channel");

endmodule

// ===== design/ers_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ers_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ers_row_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_row_queue
// Two-entry queue holding summary rows ahead of the result channel.
// ----------------------------------------------------------------------------
module ers_row_queue
  import ers_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  summary_row_t push_row,
  output logic         pop_valid,
  input  logic         pop_ready,
  output summary_row_t pop_row,
  output logic [1:0]   count
);

  summary_row_t slot [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != 2'd0);
  assign pop_row   = slot[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr_r] <= push_row;
    end
  end

endmodule

// ===== bench/event_record_summarizer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_record_summarizer_unit_test
// Drives event records of peak, cycle and unknown-type words into the
// summarizer with random source gaps and sink stalls. A per-channel record
// tracker predicts the four summary rows of every record end. Each row is
// compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module event_record_summarizer_unit_test;
  import ers_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 80;

  typedef enum {REC_CLEAN, REC_MISCOUNT, REC_PEAK_LAST, REC_BAD_TYPE} rec_kind_t;

  // tracks one record per channel and queues the rows its end produces
  class record_scoreboard_t;
    chan_acc_t    acc [CH_NUM];
    logic [20:0]  tot_peak;
    logic [20:0]  tot_cycle;
    bit           last_cycle;
    bit           bad_seen;
    summary_row_t pending_rows [$];
    int           rows_checked;
    int           status_hits [4];

    function new();
      clear();
      rows_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void clear();
      foreach (acc[i]) acc[i] = '0;
      tot_peak   = '0;
      tot_cycle  = '0;
      last_cycle = 1'b0;
      bad_seen   = 1'b0;
    endfunction

    function logic [20:0] bump(logic [20:0] v);
      return (v == MAX_RECORD_WORDS) ? v : v + 21'd1;
    endfunction

    function void note_word(logic [63:0] w, logic rec_end, logic [20:0] exp_peak,
                            logic [20:0] exp_cycle);
      logic [15:0]  raw;
      logic [16:0]  mag;
      logic [1:0]   ch;
      status_t      st;
      summary_row_t row;
      if (!bad_seen) begin
        if (w[63:56] == TYPE_PEAK) begin
          raw = w[55:40];
          mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
          ch  = w[26:25];
          tot_peak = bump(tot_peak);
          acc[ch].peak_words = bump(acc[ch].peak_words);
          if (mag > {1'b0, acc[ch].peak_max}) acc[ch].peak_max = mag[15:0];
          last_cycle = 1'b0;
        end else if (w[63:56] == TYPE_CYCLE) begin
          ch = w[31:30];
          tot_cycle = bump(tot_cycle);
          acc[ch].cycle_words  = bump(acc[ch].cycle_words);
          acc[ch].event_sum    = acc[ch].event_sum + {18'd0, w[29:16]};
          acc[ch].latest_qmax  = w[15:0];
          acc[ch].latest_index = w[55:32];
          last_cycle = 1'b1;
        end else begin
          bad_seen = 1'b1;
        end
      end
      if (!rec_end) return;
      if (bad_seen)
        st = ST_BAD_TYPE;
      else if (!last_cycle)
        st = ST_LAST_NOT_CYCLE;
      else if (tot_peak != exp_peak || tot_cycle != exp_cycle)
        st = ST_COUNT_MISMATCH;
      else
        st = ST_OK;
      for (int c = 0; c < CH_NUM; c++) begin
        row.channel            = CH_W'(c);
        row.chan_peak_words    = acc[c].peak_words;
        row.peak_magnitude_max = acc[c].peak_max;
        row.chan_cycle_words   = acc[c].cycle_words;
        row.cycle_event_sum    = acc[c].event_sum;
        row.cycle_latest_qmax  = acc[c].latest_qmax;
        row.cycle_latest_index = acc[c].latest_index;
        row.total_peak_words   = tot_peak;
        row.total_cycle_words  = tot_cycle;
        row.status             = st;
        row.last_row           = (c == CH_NUM - 1);
        pending_rows.push_back(row);
      end
      clear();
    endfunction

    function string diff(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) return $sformatf(" %s=%0h/%0h", name, got, want);
      return "";
    endfunction

    // returns an empty string when the row matches
    function string check_row(summary_row_t got);
      summary_row_t want;
      string        msg;
      if (pending_rows.size() == 0)
        return $sformatf("row for channel %0d with nothing pending", got.channel);
      want = pending_rows.pop_front();
      rows_checked++;
      status_hits[want.status]++;
      msg = {diff("channel", got.channel, want.channel),
             diff("peak_words", got.chan_peak_words, want.chan_peak_words),
             diff("peak_max", got.peak_magnitude_max, want.peak_magnitude_max),
             diff("cycle_words", got.chan_cycle_words, want.chan_cycle_words),
             diff("event_sum", got.cycle_event_sum, want.cycle_event_sum),
             diff("qmax", got.cycle_latest_qmax, want.cycle_latest_qmax),
             diff("index", got.cycle_latest_index, want.cycle_latest_index),
             diff("total_peak", got.total_peak_words, want.total_peak_words),
             diff("total_cycle", got.total_cycle_words, want.total_cycle_words),
             diff("status", got.status, want.status),
             diff("last_row", got.last_row, want.last_row)};
      if (msg != "") return {$sformatf("row ch %0d got/want:", want.channel), msg};
      return "";
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   mismatches;
  int   words_sent;
  int   records_sent;
  int   idle_cycles;

  record_scoreboard_t scoreboard;

  ers_in_if  in_ch ();
  ers_out_if out_ch ();

  event_record_summarizer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [20:0] rand21();
    return 21'($urandom);
  endfunction

  function automatic logic [63:0] make_peak(logic [1:0] ch, logic [15:0] charge);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[63:56] = TYPE_PEAK;
    w[55:40] = charge;
    w[26:25] = ch;
    return w;
  endfunction

  function automatic logic [63:0] make_cycle(logic [1:0] ch, logic [23:0] index,
                                             logic [13:0] evcnt, logic [15:0] qmax);
    return {TYPE_CYCLE, index, ch, evcnt, qmax};
  endfunction

  function automatic logic [63:0] make_bad(logic [7:0] kind);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[63:56] = kind;
    return w;
  endfunction

  function automatic logic [63:0] rand_peak();
    return make_peak(2'($urandom), 16'($urandom));
  endfunction

  function automatic logic [63:0] rand_cycle();
    return make_cycle(2'($urandom), 24'($urandom), 14'($urandom), 16'($urandom));
  endfunction

  // called right after a rising edge; returns at the edge of the transfer
  task automatic push_word(logic [63:0] w, logic rec_end, logic [20:0] exp_peak,
                           logic [20:0] exp_cycle);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid                <= 1'b1;
    in_ch.event_word           <= w;
    in_ch.record_end           <= rec_end;
    in_ch.expected_peak_words  <= exp_peak;
    in_ch.expected_cycle_words <= exp_cycle;
    do @(posedge clk); while (!in_ch.ready);
    scoreboard.note_word(w, rec_end, exp_peak, exp_cycle);
    words_sent++;
  endtask

  task automatic send_record(int len, rec_kind_t kind);
    logic [63:0] words [$];
    logic [63:0] w;
    logic [20:0] exp_peak;
    logic [20:0] exp_cycle;
    int          n_peak;
    int          n_cycle;
    int          bad_at;
    n_peak  = 0;
    n_cycle = 0;
    bad_at  = (kind == REC_BAD_TYPE) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_at)
        w = make_bad(8'($urandom_range(2, 255)));
      else if (i == len - 1)
        w = (kind == REC_PEAK_LAST) ? rand_peak() : rand_cycle();
      else
        w = $urandom_range(0, 1) ? rand_peak() : rand_cycle();
      // words after an unknown type do not count
      if (bad_at < 0 || i < bad_at) begin
        if (w[63:56] == TYPE_PEAK) n_peak++;
        else n_cycle++;
      end
      words.push_back(w);
    end
    exp_peak  = 21'(n_peak);
    exp_cycle = 21'(n_cycle);
    if (kind == REC_MISCOUNT) begin
      if ($urandom_range(0, 1)) exp_peak = exp_peak ^ (21'd1 << $urandom_range(0, 20));
      else exp_cycle = exp_cycle ^ (21'd1 << $urandom_range(0, 20));
    end
    if (kind == REC_BAD_TYPE && $urandom_range(0, 1)) begin
      exp_peak  = rand21();
      exp_cycle = rand21();
    end
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) push_word(words[i], 1'b1, exp_peak, exp_cycle);
      else push_word(words[i], 1'b0, rand21(), rand21());
    end
    records_sent++;
  endtask

  // sink side: one stall draw per summary row
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : row_monitor
    summary_row_t got;
    string        msg;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.channel            = out_ch.channel;
      got.chan_peak_words    = out_ch.chan_peak_words;
      got.peak_magnitude_max = out_ch.peak_magnitude_max;
      got.chan_cycle_words   = out_ch.chan_cycle_words;
      got.cycle_event_sum    = out_ch.cycle_event_sum;
      got.cycle_latest_qmax  = out_ch.cycle_latest_qmax;
      got.cycle_latest_index = out_ch.cycle_latest_index;
      got.total_peak_words   = out_ch.total_peak_words;
      got.total_cycle_words  = out_ch.total_cycle_words;
      got.status             = status_t'(out_ch.status);
      got.last_row           = out_ch.last_row;
      msg = scoreboard.check_row(got);
      if (msg != "") report_mismatch(msg);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n !== 1'b1) begin
      idle_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d rows pending",
                 idle_cycles, scoreboard.pending_rows.size());
        $display("event_record_summarizer_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int        random_goal;
    int        pick;
    rec_kind_t kind;
    scoreboard  = new();
    mismatches  = 0;
    words_sent  = 0;
    records_sent = 0;
    steady      = 1'b0;
    rst_n                      <= 1'b0;
    in_ch.valid                <= 1'b0;
    in_ch.event_word           <= '0;
    in_ch.record_end           <= 1'b0;
    in_ch.expected_peak_words  <= '0;
    in_ch.expected_cycle_words <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone cycle word with every field zero
    push_word(make_cycle(2'd0, 24'd0, 14'd0, 16'd0), 1'b1, 21'd0, 21'd1);
    // charge extremes, including the most negative charge, and full cycle fields
    push_word(make_peak(2'd3, 16'h8000), 1'b0, rand21(), rand21());
    push_word(make_peak(2'd3, 16'h7FFF), 1'b0, rand21(), rand21());
    push_word(make_peak(2'd1, 16'hFFFF), 1'b0, rand21(), rand21());
    push_word(make_peak(2'd0, 16'h0000), 1'b0, rand21(), rand21());
    push_word(make_peak(2'd2, 16'h8001), 1'b0, rand21(), rand21());
    push_word(make_cycle(2'd3, 24'hFFFFFF, 14'h3FFF, 16'hFFFF), 1'b0, rand21(), rand21());
    push_word(make_cycle(2'd3, 24'h000001, 14'h3FFF, 16'h0000), 1'b0, rand21(), rand21());
    push_word(make_cycle(2'd1, 24'h5A5A5A, 14'h0001, 16'h1234), 1'b0, rand21(), rand21());
    push_word(make_cycle(2'd2, 24'hA5A5A5, 14'h2AAA, 16'hFFFF), 1'b1, 21'd5, 21'd4);
    // record ending on a peak word
    push_word(make_cycle(2'd0, 24'h000010, 14'h0100, 16'h00FF), 1'b0, rand21(), rand21());
    push_word(make_peak(2'd2, 16'h4000), 1'b1, 21'd1, 21'd1);
    // count mismatch on cycles, then on peaks
    push_word(make_peak(2'd1, 16'h0123), 1'b0, rand21(), rand21());
    push_word(make_cycle(2'd1, 24'h000020, 14'h0002, 16'h0002), 1'b1, 21'd1, 21'd2);
    push_word(make_cycle(2'd0, 24'h000030, 14'h0003, 16'h0003), 1'b1, 21'h1FFFFF, 21'd1);
    // unknown type mid-record: later words and the end word are ignored
    push_word(make_peak(2'd0, 16'h0100), 1'b0, rand21(), rand21());
    push_word(make_bad(8'd2), 1'b0, rand21(), rand21());
    push_word(make_peak(2'd0, 16'h7000), 1'b0, rand21(), rand21());
    push_word(make_cycle(2'd0, 24'h000040, 14'h0004, 16'h0004), 1'b1, 21'd1, 21'd0);
    // unknown type on the end word itself
    push_word(make_cycle(2'd1, 24'h000050, 14'h0005, 16'h0005), 1'b0, rand21(), rand21());
    push_word(make_bad(8'hFF), 1'b1, 21'd0, 21'd1);
    records_sent = records_sent + 7;

    random_goal = words_sent + RANDOM_WORDS;
    while (words_sent < random_goal) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 9);
      kind   = (pick < 6) ? REC_CLEAN :
               (pick == 6) ? REC_MISCOUNT :
               (pick == 7) ? REC_PEAK_LAST : REC_BAD_TYPE;
      send_record($urandom_range(1, 8), kind);
    end
    in_ch.valid <= 1'b0;
    steady = 1'b0;

    while (scoreboard.pending_rows.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run: %0d records in %0d event words, %0d summary rows compared",
             records_sent, words_sent, scoreboard.rows_checked);
    $display("row status: ok %0d, unknown type %0d, last not cycle %0d, count mismatch %0d",
             scoreboard.status_hits[ST_OK], scoreboard.status_hits[ST_BAD_TYPE],
             scoreboard.status_hits[ST_LAST_NOT_CYCLE],
             scoreboard.status_hits[ST_COUNT_MISMATCH]);
    if (scoreboard.pending_rows.size() != 0)
      report_mismatch($sformatf("%0d rows never arrived", scoreboard.pending_rows.size()));
    if (mismatches == 0) begin
      $display("event_record_summarizer_unit test passed");
    end else begin
      $display("event_record_summarizer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ers_pkg.sv
design/ers_if.sv
design/ers_ram.sv
design/ers_row_queue.sv
design/event_record_summarizer_unit.sv
bench/event_record_summarizer_unit_test.sv
